[sv/assert_macros.svh]
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/su3r_pkg.sv]
// ----------------------------------------------------------------------------
// su3r_pkg
// Shared types and constants for the SU(3) third-row rebuild block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package su3r_pkg;

  localparam int SU3R_DATA_WIDTH = 32;
  localparam int NUM_ROWS        = 3;
  localparam int ROW_W           = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 1;

  localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
  localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRANSPOSE = 2'd0,
    CFG_REBUILD   = 2'd1
  } cfg_idx_t;

  // Load strobes for the two arithmetic stages of the cross-product unit.
  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } stage_ctl_t;

endpackage

[sv/su3r_conj_diff.sv]
// ----------------------------------------------------------------------------
// su3r_conj_diff
// One component of c = conj(x*y - z*w): a product stage (eight exact
// products) followed by a sum stage (exact sum, floor shift, saturate).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module su3r_conj_diff #(
  parameter int DATA_WIDTH = su3r_pkg::SU3R_DATA_WIDTH
) (
  input  logic                          clk,
  input  su3r_pkg::stage_ctl_t          ctl,
  input  logic signed [DATA_WIDTH-1:0]  x_re,
  input  logic signed [DATA_WIDTH-1:0]  x_im,
  input  logic signed [DATA_WIDTH-1:0]  y_re,
  input  logic signed [DATA_WIDTH-1:0]  y_im,
  input  logic signed [DATA_WIDTH-1:0]  z_re,
  input  logic signed [DATA_WIDTH-1:0]  z_im,
  input  logic signed [DATA_WIDTH-1:0]  w_re,
  input  logic signed [DATA_WIDTH-1:0]  w_im,
  output logic signed [DATA_WIDTH-1:0]  c_re,
  output logic signed [DATA_WIDTH-1:0]  c_im
);
  import su3r_pkg::*;

  localparam int PW   = 2 * DATA_WIDTH;
  localparam int SW   = PW + 2;            // room for four full-scale terms
  localparam int FRAC = DATA_WIDTH - 2;

  localparam logic signed [SW-1:0] MAXV = {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  logic signed [PW-1:0] p [8];

  logic signed [SW-1:0] re_sum, im_sum, re_q, im_q;
  logic signed [DATA_WIDTH-1:0] re_sat, im_sat;

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      p[0] <= x_re * y_re;
      p[1] <= x_im * y_im;
      p[2] <= z_re * w_re;
      p[3] <= z_im * w_im;
      p[4] <= x_re * y_im;
      p[5] <= x_im * y_re;
      p[6] <= z_re * w_im;
      p[7] <= z_im * w_re;
    end
  end

  always_comb begin
    re_sum = SW'(p[0]) - SW'(p[1]) - SW'(p[2]) + SW'(p[3]);
    // conjugate: sign of the imaginary part flipped on the exact sum
    im_sum = SW'(p[6]) + SW'(p[7]) - SW'(p[4]) - SW'(p[5]);
    re_q   = re_sum >>> FRAC;              // arithmetic shift = floor
    im_q   = im_sum >>> FRAC;

    if (re_q > MAXV)      re_sat = MAXV[DATA_WIDTH-1:0];
    else if (re_q < MINV) re_sat = MINV[DATA_WIDTH-1:0];
    else                  re_sat = re_q[DATA_WIDTH-1:0];

    if (im_q > MAXV)      im_sat = MAXV[DATA_WIDTH-1:0];
    else if (im_q < MINV) im_sat = MINV[DATA_WIDTH-1:0];
    else                  im_sat = im_q[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      c_re <= re_sat;
      c_im <= im_sat;
    end
  end

endmodule

[sv/su3_third_row_rebuild.sv]
// ----------------------------------------------------------------------------
// su3_third_row_rebuild
// Rebuilds the third vector of a compressed 3x3 complex link matrix and
// streams the full matrix out as three rows.
// ----------------------------------------------------------------------------
// Each accepted beat (vectors a and b, Q2.30) produces three result beats,
// rows 0..2, one per cycle when out_ready is high; last_row marks row 2.
// The path is input register, product register, sum/saturate register and
// output register; rows are presented from the output register. The single
// result channel limits the sustained rate, since each matrix needs three
// result beats; input beats are taken every cycle while the pipeline has
// room, including while a result waits on out_ready.
// Config (transpose_out, rebuild_enable) is ready whenever reset is low; the
// user must write it only between matrices, which the block does not enforce.
`timescale 1ns / 1ps

module su3_third_row_rebuild #(
  parameter int DATA_WIDTH = su3r_pkg::SU3R_DATA_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [su3r_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [su3r_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [DATA_WIDTH-1:0]      a0_re,
  input  logic signed [DATA_WIDTH-1:0]      a0_im,
  input  logic signed [DATA_WIDTH-1:0]      b0_re,
  input  logic signed [DATA_WIDTH-1:0]      b0_im,
  input  logic signed [DATA_WIDTH-1:0]      a1_re,
  input  logic signed [DATA_WIDTH-1:0]      a1_im,
  input  logic signed [DATA_WIDTH-1:0]      b1_re,
  input  logic signed [DATA_WIDTH-1:0]      b1_im,
  input  logic signed [DATA_WIDTH-1:0]      a2_re,
  input  logic signed [DATA_WIDTH-1:0]      a2_im,
  input  logic signed [DATA_WIDTH-1:0]      b2_re,
  input  logic signed [DATA_WIDTH-1:0]      b2_im,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [su3r_pkg::ROW_W-1:0]        row_index,
  output logic                              last_row,
  output logic signed [DATA_WIDTH-1:0]      e0_re,
  output logic signed [DATA_WIDTH-1:0]      e0_im,
  output logic signed [DATA_WIDTH-1:0]      e1_re,
  output logic signed [DATA_WIDTH-1:0]      e1_im,
  output logic signed [DATA_WIDTH-1:0]      e2_re,
  output logic signed [DATA_WIDTH-1:0]      e2_im
);
  import su3r_pkg::*;

  `include "assert_macros.svh"

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  // config registers
  logic transpose_out, rebuild_enable;

  // pipeline valids
  logic v0, v1, v2;
  logic ld1, ld2, take, adv2;
  logic [ROW_W-1:0] row_cnt, row_cnt_next;

  // stage payload
  word_t s0_a_re [NUM_ROWS], s0_a_im [NUM_ROWS], s0_b_re [NUM_ROWS], s0_b_im [NUM_ROWS];
  word_t s1_a_re [NUM_ROWS], s1_a_im [NUM_ROWS], s1_b_re [NUM_ROWS], s1_b_im [NUM_ROWS];
  word_t s2_a_re [NUM_ROWS], s2_a_im [NUM_ROWS], s2_b_re [NUM_ROWS], s2_b_im [NUM_ROWS];
  word_t c_re [NUM_ROWS], c_im [NUM_ROWS];

  word_t mat_re [NUM_ROWS][NUM_ROWS];
  word_t mat_im [NUM_ROWS][NUM_ROWS];
  word_t row_re [NUM_ROWS], row_im [NUM_ROWS];
  word_t e_re [NUM_ROWS], e_im [NUM_ROWS];

  stage_ctl_t ctl;

  // ---------------- config ----------------
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      transpose_out  <= 1'b0;
      rebuild_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TRANSPOSE: transpose_out  <= cfg_data[0];
        CFG_REBUILD:   rebuild_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  always_comb begin
    take     = v2 && (!out_valid || out_ready);
    adv2     = take && (row_cnt == ROW_LAST);
    ld2      = v1 && (!v2 || adv2);
    ld1      = v0 && (!v1 || ld2);
    in_ready = !rst && (!v0 || ld1);
    ctl.ld_prod = ld1;
    ctl.ld_sum  = ld2;
    if (adv2)      row_cnt_next = ROW_FIRST;
    else if (take) row_cnt_next = row_cnt + ROW_W'(1);
    else           row_cnt_next = row_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      row_cnt   <= ROW_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) v0 <= 1'b1;
      else if (ld1)             v0 <= 1'b0;
      if (ld1)                  v1 <= 1'b1;
      else if (ld2)             v1 <= 1'b0;
      if (ld2)                  v2 <= 1'b1;
      else if (adv2)            v2 <= 1'b0;
      row_cnt <= row_cnt_next;
      if (take)                 out_valid <= 1'b1;
      else if (out_ready)       out_valid <= 1'b0;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_a_re[0] <= a0_re; s0_a_im[0] <= a0_im; s0_b_re[0] <= b0_re; s0_b_im[0] <= b0_im;
      s0_a_re[1] <= a1_re; s0_a_im[1] <= a1_im; s0_b_re[1] <= b1_re; s0_b_im[1] <= b1_im;
      s0_a_re[2] <= a2_re; s0_a_im[2] <= a2_im; s0_b_re[2] <= b2_re; s0_b_im[2] <= b2_im;
    end
    if (ld1) begin
      s1_a_re <= s0_a_re; s1_a_im <= s0_a_im;
      s1_b_re <= s0_b_re; s1_b_im <= s0_b_im;
    end
    if (ld2) begin
      s2_a_re <= s1_a_re; s2_a_im <= s1_a_im;
      s2_b_re <= s1_b_re; s2_b_im <= s1_b_im;
    end
  end

  // ---------------- c = conj(a x b) ----------------
  // c0 = conj(a1 b2 - b1 a2)
  su3r_conj_diff #(.DATA_WIDTH(DATA_WIDTH)) u_c0 (
    .clk (clk), .ctl (ctl),
    .x_re (s0_a_re[1]), .x_im (s0_a_im[1]), .y_re (s0_b_re[2]), .y_im (s0_b_im[2]),
    .z_re (s0_b_re[1]), .z_im (s0_b_im[1]), .w_re (s0_a_re[2]), .w_im (s0_a_im[2]),
    .c_re (c_re[0]), .c_im (c_im[0])
  );

  // c1 = conj(b0 a2 - a0 b2)
  su3r_conj_diff #(.DATA_WIDTH(DATA_WIDTH)) u_c1 (
    .clk (clk), .ctl (ctl),
    .x_re (s0_b_re[0]), .x_im (s0_b_im[0]), .y_re (s0_a_re[2]), .y_im (s0_a_im[2]),
    .z_re (s0_a_re[0]), .z_im (s0_a_im[0]), .w_re (s0_b_re[2]), .w_im (s0_b_im[2]),
    .c_re (c_re[1]), .c_im (c_im[1])
  );

  // c2 = conj(a0 b1 - b0 a1)
  su3r_conj_diff #(.DATA_WIDTH(DATA_WIDTH)) u_c2 (
    .clk (clk), .ctl (ctl),
    .x_re (s0_a_re[0]), .x_im (s0_a_im[0]), .y_re (s0_b_re[1]), .y_im (s0_b_im[1]),
    .z_re (s0_b_re[0]), .z_im (s0_b_im[0]), .w_re (s0_a_re[1]), .w_im (s0_a_im[1]),
    .c_re (c_re[2]), .c_im (c_im[2])
  );

  // ---------------- row select ----------------
  // mat[v][k]: vector v (a, b, c), element k
  always_comb begin
    for (int k = 0; k < NUM_ROWS; k++) begin
      mat_re[0][k] = s2_a_re[k];
      mat_im[0][k] = s2_a_im[k];
      mat_re[1][k] = s2_b_re[k];
      mat_im[1][k] = s2_b_im[k];
      mat_re[2][k] = rebuild_enable ? c_re[k] : '0;
      mat_im[2][k] = rebuild_enable ? c_im[k] : '0;
    end
    for (int j = 0; j < NUM_ROWS; j++) begin
      row_re[j] = transpose_out ? mat_re[row_cnt][j] : mat_re[j][row_cnt];
      row_im[j] = transpose_out ? mat_im[row_cnt][j] : mat_im[j][row_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      row_index <= row_cnt;
      last_row  <= (row_cnt == ROW_LAST);
      e_re      <= row_re;
      e_im      <= row_im;
    end
  end

  assign e0_re = e_re[0];
  assign e0_im = e_im[0];
  assign e1_re = e_re[1];
  assign e1_im = e_im[1];
  assign e2_re = e_re[2];
  assign e2_im = e_im[2];

  // ---------------- checks ----------------
  `ASSERT_ALWAYS(a_row_cnt_range, row_cnt != 2'd3, "row counter out of range")
  `ASSERT_IMPLIES(a_last_flag, out_valid, last_row == (row_index == ROW_LAST), "last_row mismatch")
  `ASSERT_NEXT(a_row_order, take, row_index == $past(row_cnt), "row beat out of order")
  `ASSERT_NEXT(a_matrix_held, v2 && !adv2, v2, "matrix dropped before last row")

endmodule

[test/su3r_row_checker.sv]
// ----------------------------------------------------------------------------
// su3r_row_checker
// Watches the config, input and result channels of su3_third_row_rebuild.
// It predicts the three row beats of every matrix taken and checks each
// result beat against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module su3r_row_checker #(
  parameter int W = su3r_pkg::SU3R_DATA_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [su3r_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [su3r_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic signed [W-1:0]             a0_re,
  input  logic signed [W-1:0]             a0_im,
  input  logic signed [W-1:0]             b0_re,
  input  logic signed [W-1:0]             b0_im,
  input  logic signed [W-1:0]             a1_re,
  input  logic signed [W-1:0]             a1_im,
  input  logic signed [W-1:0]             b1_re,
  input  logic signed [W-1:0]             b1_im,
  input  logic signed [W-1:0]             a2_re,
  input  logic signed [W-1:0]             a2_im,
  input  logic signed [W-1:0]             b2_re,
  input  logic signed [W-1:0]             b2_im,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [su3r_pkg::ROW_W-1:0]      row_index,
  input  logic                            last_row,
  input  logic signed [W-1:0]             e0_re,
  input  logic signed [W-1:0]             e0_im,
  input  logic signed [W-1:0]             e1_re,
  input  logic signed [W-1:0]             e1_im,
  input  logic signed [W-1:0]             e2_re,
  input  logic signed [W-1:0]             e2_im,
  output int                              mismatches,
  output int                              rows_pending
);

  import su3r_pkg::*;

  localparam int FRAC_BITS = W - 2;
  localparam int ACC_W     = 2 * W + 6;
  localparam int PRINT_CAP = 60;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t Q_MAX = {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam acc_t Q_MIN = {{(ACC_W-W+1){1'b1}}, {(W-1){1'b0}}};

  typedef struct packed {
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
  } cplx_t;

  // elem[0] = e0_re, elem[1] = e0_im, ... elem[5] = e2_im
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic              last;
    logic [5:0][W-1:0] elem;
  } row_beat_t;

  row_beat_t expected_rows[$];
  logic      transpose_q;
  logic      rebuild_q;
  int        err_count = 0;
  int        beat_no   = 0;
  string     elem_name [6] = '{"e0_re", "e0_im", "e1_re", "e1_im", "e2_re", "e2_im"};

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    if (err_count < PRINT_CAP)
      $display("%0t: row beat %0d: %s got %h, expected %h", $time, beat_no, what, got, want);
    err_count++;
  endtask

  // exact sum, floor shift to Q2.30, clamp to the data width
  function automatic logic [W-1:0] floor_sat(input acc_t sum);
    acc_t q;
    q = sum >>> FRAC_BITS;
    if (q > Q_MAX) return Q_MAX[W-1:0];
    if (q < Q_MIN) return Q_MIN[W-1:0];
    return q[W-1:0];
  endfunction

  // conj(x*y - z*w)
  function automatic cplx_t conj_diff(input cplx_t x, input cplx_t y,
                                      input cplx_t z, input cplx_t w);
    acc_t  xr, xi, yr, yi, zr, zi, wr, wi;
    cplx_t c;
    xr = $signed(x.re); xi = $signed(x.im);
    yr = $signed(y.re); yi = $signed(y.im);
    zr = $signed(z.re); zi = $signed(z.im);
    wr = $signed(w.re); wi = $signed(w.im);
    c.re = floor_sat(xr * yr - xi * yi - zr * wr + zi * wi);
    c.im = floor_sat(-(xr * yi) - xi * yr + zr * wi + zi * wr);
    return c;
  endfunction

  function automatic void predict_rows(input cplx_t va[3], input cplx_t vb[3]);
    cplx_t     mat [3][3];
    cplx_t     e;
    row_beat_t beat;
    for (int k = 0; k < 3; k++) begin
      mat[0][k] = va[k];
      mat[1][k] = vb[k];
      mat[2][k] = '0;
    end
    if (rebuild_q) begin
      mat[2][0] = conj_diff(va[1], vb[2], vb[1], va[2]);
      mat[2][1] = conj_diff(vb[0], va[2], va[0], vb[2]);
      mat[2][2] = conj_diff(va[0], vb[1], vb[0], va[1]);
    end
    for (int k = 0; k < 3; k++) begin
      beat.row  = ROW_W'(k);
      beat.last = (beat.row == ROW_LAST);
      for (int j = 0; j < 3; j++) begin
        e = transpose_q ? mat[k][j] : mat[j][k];
        beat.elem[2*j]   = e.re;
        beat.elem[2*j+1] = e.im;
      end
      expected_rows.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    cplx_t     va [3];
    cplx_t     vb [3];
    row_beat_t seen;
    row_beat_t want;
    if (rst) begin
      expected_rows.delete();
      transpose_q = 1'b0;
      rebuild_q   = 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TRANSPOSE: transpose_q = cfg_data[0];
          CFG_REBUILD:   rebuild_q   = cfg_data[0];
          default: ;  // unmapped index, no effect
        endcase
      end
      if (in_valid && in_ready) begin
        va[0] = {a0_re, a0_im}; vb[0] = {b0_re, b0_im};
        va[1] = {a1_re, a1_im}; vb[1] = {b1_re, b1_im};
        va[2] = {a2_re, a2_im}; vb[2] = {b2_re, b2_im};
        predict_rows(va, vb);
      end
      if (out_valid && out_ready) begin
        seen.row  = row_index;
        seen.last = last_row;
        seen.elem = {e2_im, e2_re, e1_im, e1_re, e0_im, e0_re};
        if (expected_rows.size() == 0) begin
          report_mismatch("beat with nothing expected, row_index", W'(row_index), '0);
        end else begin
          want = expected_rows.pop_front();
          if (seen.row !== want.row)
            report_mismatch("row_index", W'(seen.row), W'(want.row));
          if (seen.last !== want.last)
            report_mismatch("last_row", W'(seen.last), W'(want.last));
          for (int j = 0; j < 6; j++)
            if (seen.elem[j] !== want.elem[j])
              report_mismatch(elem_name[j], seen.elem[j], want.elem[j]);
        end
        beat_no++;
      end
    end
    rows_pending <= expected_rows.size();
    mismatches   <= err_count;
  end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for su3_third_row_rebuild. Directed matrices (zero,
// extremes, identity, saturation both ways, floor rounding, bit patterns)
// then random matrices over all register settings, with random stalls on
// both channels and a long receiver hold-off. Checking lives in
// su3r_row_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import su3r_pkg::*;

  localparam int W = SU3R_DATA_WIDTH;

  localparam logic [W-1:0] MAX_W   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_W   = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_Q   = {2'b01, {(W-2){1'b0}}};
  localparam logic [W-1:0] NEG_ONE = {2'b11, {(W-2){1'b0}}};
  localparam logic [W-1:0] PAT_A   = {(W/2){2'b10}};
  localparam logic [W-1:0] PAT_5   = {(W/2){2'b01}};

  // indexes outside the register map
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  // word positions of one input beat
  localparam int F_A0_RE = 0, F_A0_IM = 1, F_B0_RE = 2,  F_B0_IM = 3;
  localparam int F_A1_RE = 4, F_A1_IM = 5, F_B1_RE = 6,  F_B1_IM = 7;
  localparam int F_A2_RE = 8, F_A2_IM = 9, F_B2_RE = 10, F_B2_IM = 11;

  localparam int RAND_PER_BURST = 52;
  localparam int HOLD_CYCLES    = 300;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [W-1:0]   a0_re, a0_im, b0_re, b0_im;
  logic signed [W-1:0]   a1_re, a1_im, b1_re, b1_im;
  logic signed [W-1:0]   a2_re, a2_im, b2_re, b2_im;
  logic                  out_valid;
  logic                  out_ready;
  logic [ROW_W-1:0]      row_index;
  logic                  last_row;
  logic signed [W-1:0]   e0_re, e0_im, e1_re, e1_im, e2_re, e2_im;
  int                    mismatches;
  int                    rows_pending;

  int in_idle_pct  = 6;
  int out_idle_pct = 48;
  int hold_left    = 0;

  su3_third_row_rebuild u_top (.*);

  su3r_row_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("[su3_third_row_rebuild] ERROR");
    $finish;
  end

  function automatic logic [W-1:0] edge_word(input int n);
    case (n)
      0:       return MAX_W;
      1:       return MIN_W;
      2:       return '0;
      3:       return '1;
      4:       return W'(1);
      5:       return ONE_Q;
      default: return NEG_ONE;
    endcase
  endfunction

  function automatic void fill_directed(input int n, output logic [W-1:0] w[12]);
    for (int i = 0; i < 12; i++) w[i] = '0;
    case (n)
      0: ;
      1: for (int i = 0; i < 12; i++) w[i] = MAX_W;
      2: for (int i = 0; i < 12; i++) w[i] = MIN_W;
      3: for (int i = 0; i < 12; i++) w[i] = '1;
      4: begin
        w[F_A0_RE] = ONE_Q;
        w[F_B1_RE] = ONE_Q;
      end
      5: begin  // clamps high on c0.re and c2.im, low on c1.im
        w[F_A1_RE] = MAX_W; w[F_B2_RE] = MAX_W;
        w[F_B1_RE] = MAX_W; w[F_A2_RE] = MIN_W;
        w[F_A0_IM] = MIN_W;
      end
      6: begin  // the opposite clamps
        w[F_A1_RE] = MIN_W; w[F_B2_RE] = MAX_W;
        w[F_B1_RE] = MAX_W; w[F_A2_RE] = MAX_W;
        w[F_A0_IM] = MAX_W;
      end
      7: begin  // tiny products: -1 lsb floors to -1, +1 lsb floors to 0
        w[F_A1_RE] = W'(1); w[F_B2_RE] = '1;
        w[F_A0_RE] = W'(1); w[F_B1_RE] = W'(1);
        w[F_B0_IM] = ONE_Q; w[F_A2_IM] = NEG_ONE;
      end
      8: for (int i = 0; i < 12; i++) w[i] = i[0] ? PAT_5 : PAT_A;
      default: for (int i = 0; i < 12; i++) w[i] = i[0] ? PAT_A : PAT_5;
    endcase
  endfunction

  function automatic void fill_random(output logic [W-1:0] w[12]);
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) begin
      if (kind < 5)
        w[i] = $urandom;
      else if (kind < 8)  // near-unitary magnitudes
        w[i] = $urandom_range(0, 2 * ONE_Q) - ONE_Q;
      else
        w[i] = $urandom_range(1) ? edge_word($urandom_range(0, 6)) : W'($urandom);
    end
  endfunction

  task automatic send_matrix(input logic [W-1:0] w[12]);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    a0_re <= w[F_A0_RE]; a0_im <= w[F_A0_IM]; b0_re <= w[F_B0_RE]; b0_im <= w[F_B0_IM];
    a1_re <= w[F_A1_RE]; a1_im <= w[F_A1_IM]; b1_re <= w[F_B1_RE]; b1_im <= w[F_B1_IM];
    a2_re <= w[F_A2_RE]; a2_im <= w[F_A2_IM]; b2_re <= w[F_B2_RE]; b2_im <= w[F_B2_IM];
    do @(posedge clk); while (!in_ready);
  endtask

  // every matrix yields rows, so an empty queue plus pipeline slack is idle
  task automatic wait_idle();
    do @(posedge clk); while (rows_pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [W-1:0] w [12];
    int           combo;
    int           guard;
    int           fails;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_TRANSPOSE;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    {a0_re, a0_im, b0_re, b0_im} <= '0;
    {a1_re, a1_im, b1_re, b1_im} <= '0;
    {a2_re, a2_im, b2_re, b2_im} <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed set at reset config, then transposed with rebuild off
    for (int n = 0; n < 10; n++) begin
      fill_directed(n, w);
      send_matrix(w);
    end
    in_valid <= 1'b0;
    wait_idle();
    write_reg(CFG_TRANSPOSE, 1'b1);
    write_reg(CFG_REBUILD, 1'b0);
    // unmapped indexes must leave both registers alone
    write_reg(CFG_IDX_SPARE_A, 1'b0);
    write_reg(CFG_IDX_SPARE_B, 1'b1);
    for (int n = 0; n < 10; n++) begin
      fill_directed(n, w);
      send_matrix(w);
    end
    in_valid <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin in_idle_pct = 6;  out_idle_pct = 48; end
        1:       begin in_idle_pct = 48; out_idle_pct = 6;  end
        default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
      endcase
      for (int part = 0; part < 2; part++) begin
        combo = (phase * 2 + part) % 4;
        wait_idle();
        write_reg(CFG_TRANSPOSE, combo[0]);
        write_reg(CFG_REBUILD, combo[1]);
        // back-pressure: receiver stalls long while beats keep coming
        if (phase == 2 && part == 0) hold_left = HOLD_CYCLES;
        for (int i = 0; i < RAND_PER_BURST; i++) begin
          fill_random(w);
          send_matrix(w);
        end
        in_valid <= 1'b0;
      end
    end

    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (rows_pending != 0 && guard < 20000);
    repeat (10) @(posedge clk);
    fails = mismatches + rows_pending;
    if (fails == 0)
      $display("[su3_third_row_rebuild] OK");
    else
      $display("[su3_third_row_rebuild] ERROR");
    $finish;
  end

endmodule
